// ===== rtl/ofvr_pkg.sv =====
package ofvr_pkg;

    // Configurable widths
    localparam int STAMP_BITS = 48;
    localparam int ANGLE_BITS = 16;

    // Item field widths
    localparam int STATUS_BITS   = 8;
    localparam int BYTE_BITS     = 8;
    localparam int COUNT_BITS    = 16;
    localparam int HEADING_BITS  = 16;
    localparam int STAMP_IN_BITS = 48;
    localparam int VEL_BITS      = 18;

    // Register widths
    localparam int SCALE_BITS  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int LIMIT_BITS  = 17;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(100000);

    // APB
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = PADDR_BITS - 2;

    // Sample qualification
    localparam int                   MOTION_BIT   = 7;
    localparam logic [BYTE_BITS-1:0] QUALITY_MIN  = 8'h19;
    localparam logic [BYTE_BITS-1:0] SHUTTER_FAKE = 8'h1F;

    // Scaling divider
    localparam int MAG_BITS     = COUNT_BITS + SCALE_BITS;
    localparam int QUO_BITS     = 31;
    localparam int SC_BITS      = QUO_BITS + 1;
    localparam int QUO_CNT_BITS = $clog2(QUO_BITS);

    // CORDIC
    localparam int CORD_BITS     = 32;
    localparam int CORD_STEPS    = 30;
    localparam int CORD_CNT_BITS = $clog2(CORD_STEPS);
    localparam logic signed [CORD_BITS-1:0] CORD_GAIN = 32'sd652032874;

    // Serial rotation multiply
    localparam int TERM_BITS    = SC_BITS + 2;
    localparam int HI_BITS      = SC_BITS + 3;
    localparam int LO_BITS      = CORD_BITS;
    localparam int ROUND_SHIFT  = 30;
    localparam int VAL_BITS     = HI_BITS + LO_BITS - ROUND_SHIFT;
    localparam int MUL_CNT_BITS = $clog2(CORD_BITS);
    localparam logic [LO_BITS:0] ROUND_HALF = (LO_BITS + 1)'(1) << (ROUND_SHIFT - 1);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SCALE  = 2'd0,
        REG_OFFSET = 2'd1,
        REG_LIMIT  = 2'd2
    } ofvr_reg_t;

    typedef struct packed {
        logic [SCALE_BITS-1:0]  scale;
        logic [OFFSET_BITS-1:0] offset;
        logic [LIMIT_BITS-1:0]  limit;
    } ofvr_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SOLVE,
        ST_TURN,
        ST_ROTATE,
        ST_EMIT
    } ofvr_state_t;

    // arctan(2^-i) as a fraction of a full turn, 32-bit
    function automatic logic [CORD_BITS-1:0] ofvr_atan(input logic [CORD_CNT_BITS-1:0] idx);
        logic [CORD_BITS-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000028;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000002;
            5'd29:   v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ofvr_ifs.sv =====
interface ofvr_in_if import ofvr_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic        [STATUS_BITS-1:0]  motion_status;
    logic signed [COUNT_BITS-1:0]   flow_x;
    logic signed [COUNT_BITS-1:0]   flow_y;
    logic        [BYTE_BITS-1:0]    surface_quality;
    logic        [BYTE_BITS-1:0]    shutter_upper;
    logic        [HEADING_BITS-1:0] heading;
    logic        [STAMP_IN_BITS-1:0] stamp_us;

    modport source (
        output valid, motion_status, flow_x, flow_y, surface_quality,
               shutter_upper, heading, stamp_us,
        input  ready
    );

    modport sink (
        input  valid, motion_status, flow_x, flow_y, surface_quality,
               shutter_upper, heading, stamp_us,
        output ready
    );
endinterface

interface ofvr_out_if import ofvr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VEL_BITS-1:0] vel_x;
    logic signed [VEL_BITS-1:0] vel_y;
    logic                       moved;

    modport source (
        output valid, vel_x, vel_y, moved,
        input  ready
    );

    modport sink (
        input  valid, vel_x, vel_y, moved,
        output ready
    );
endinterface

// ===== rtl/ofvr_cfg.sv =====
module ofvr_cfg import ofvr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output ofvr_cfg_t             cfg
);

    logic [SCALE_BITS-1:0]  scale_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;
    ofvr_reg_t              idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = ofvr_reg_t'(paddr[PADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= '0;
            offset_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SCALE:  scale_reg  <= pwdata[SCALE_BITS-1:0];
                REG_OFFSET: offset_reg <= pwdata[OFFSET_BITS-1:0];
                REG_LIMIT:  limit_reg  <= pwdata[LIMIT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SCALE:  prdata = PDATA_BITS'(scale_reg);
            REG_OFFSET: prdata = PDATA_BITS'(offset_reg);
            REG_LIMIT:  prdata = PDATA_BITS'(limit_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.scale  = scale_reg;
    assign cfg.offset = offset_reg;
    assign cfg.limit  = limit_reg;

endmodule

// ===== rtl/ofvr_div.sv =====
module ofvr_div import ofvr_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [COUNT_BITS-1:0] count,
    input  logic [SCALE_BITS-1:0]      scale,
    input  logic [STAMP_BITS-1:0]      dt,
    output logic                       busy,
    output logic signed [SC_BITS-1:0]  scaled
);

    logic                     busy_reg;
    logic                     first_reg;
    logic [QUO_CNT_BITS-1:0]  cnt_reg;
    logic [MAG_BITS-1:0]      mag_reg;
    logic [MAG_BITS-1:0]      mag_next;
    logic                     neg_reg;
    logic                     sat_reg;
    logic [STAMP_BITS-1:0]    rem_reg;
    logic [STAMP_BITS-1:0]    rem_next;
    logic [QUO_BITS-1:0]      quo_reg;
    logic [COUNT_BITS-1:0]    abs_count;
    logic [STAMP_BITS:0]      trial;
    logic [STAMP_BITS:0]      diff;
    logic                     ge;
    logic [STAMP_BITS-1:0]    mag_hi;
    logic [QUO_BITS-1:0]      mag_q;
    logic                     last;

    assign abs_count = count[COUNT_BITS-1] ? COUNT_BITS'(-count) : COUNT_BITS'(count);
    assign mag_next  = MAG_BITS'(abs_count) * MAG_BITS'(scale);

    // Quotient overflows 31 bits exactly when the upper dividend bits reach dt
    assign mag_hi = STAMP_BITS'(mag_reg[MAG_BITS-1:QUO_BITS]);

    // one restoring step per cycle, dividend bits enter from the shift register
    assign trial    = {rem_reg, mag_reg[QUO_BITS-1]};
    assign ge       = trial >= {1'b0, dt};
    assign diff     = trial - {1'b0, dt};
    assign rem_next = ge ? diff[STAMP_BITS-1:0] : trial[STAMP_BITS-1:0];
    assign last     = cnt_reg == QUO_CNT_BITS'(QUO_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            first_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                first_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag_next;
            neg_reg <= count[COUNT_BITS-1];
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                sat_reg <= mag_hi >= dt;
                rem_reg <= mag_hi;
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
                mag_reg <= {mag_reg[MAG_BITS-2:0], 1'b0};
            end
        end
    end

    assign mag_q  = sat_reg ? {QUO_BITS{1'b1}} : quo_reg;
    assign scaled = neg_reg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    assign busy   = busy_reg;

endmodule

// ===== rtl/ofvr_cordic.sv =====
module ofvr_cordic import ofvr_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ANGLE_BITS-1:0]       angle,
    output logic                        busy,
    output logic signed [CORD_BITS-1:0] cos_q,
    output logic signed [CORD_BITS-1:0] sin_q
);

    logic                        busy_reg;
    logic [CORD_CNT_BITS-1:0]    cnt_reg;
    logic signed [CORD_BITS-1:0] x_reg;
    logic signed [CORD_BITS-1:0] y_reg;
    logic signed [CORD_BITS-1:0] z_reg;
    logic                        flip_reg;
    logic [CORD_BITS-1:0]        turn;
    logic                        flip;
    logic signed [CORD_BITS-1:0] dx;
    logic signed [CORD_BITS-1:0] dy;
    logic signed [CORD_BITS-1:0] atan_step;

    assign turn = {angle, {(CORD_BITS - ANGLE_BITS){1'b0}}};
    // fold into [-1/4, 1/4) turn; folded result is negated at the end
    assign flip = turn[CORD_BITS-1] ^ turn[CORD_BITS-2];

    assign dx        = y_reg >>> cnt_reg;
    assign dy        = x_reg >>> cnt_reg;
    assign atan_step = $signed(ofvr_atan(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CORD_CNT_BITS'(CORD_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORD_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({turn[CORD_BITS-1] ^ flip, turn[CORD_BITS-2:0]});
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORD_BITS-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_step;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_step;
            end
        end
    end

    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;
    assign busy  = busy_reg;

endmodule

// ===== rtl/ofvr_rot.sv =====
module ofvr_rot import ofvr_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SC_BITS-1:0]   sx,
    input  logic signed [SC_BITS-1:0]   sy,
    input  logic signed [CORD_BITS-1:0] cos_q,
    input  logic signed [CORD_BITS-1:0] sin_q,
    input  logic [LIMIT_BITS-1:0]       limit,
    output logic                        busy,
    output logic signed [VEL_BITS-1:0]  vel_x,
    output logic signed [VEL_BITS-1:0]  vel_y
);

    logic                        busy_reg;
    logic [MUL_CNT_BITS-1:0]     cnt_reg;
    logic signed [SC_BITS-1:0]   ax_reg;
    logic signed [SC_BITS-1:0]   ay_reg;
    logic [CORD_BITS-1:0]        cb_reg;
    logic [CORD_BITS-1:0]        sb_reg;
    logic signed [HI_BITS-1:0]   hx_reg;
    logic signed [HI_BITS-1:0]   hy_reg;
    logic [LO_BITS-1:0]          lx_reg;
    logic [LO_BITS-1:0]          ly_reg;
    logic                        last;
    logic signed [TERM_BITS-1:0] p_cx;
    logic signed [TERM_BITS-1:0] p_sy;
    logic signed [TERM_BITS-1:0] p_sx;
    logic signed [TERM_BITS-1:0] p_cy;
    logic signed [TERM_BITS-1:0] tx_raw;
    logic signed [TERM_BITS-1:0] ty_raw;
    logic signed [TERM_BITS-1:0] tx;
    logic signed [TERM_BITS-1:0] ty;
    logic signed [HI_BITS-1:0]   sum_x;
    logic signed [HI_BITS-1:0]   sum_y;
    logic [LO_BITS:0]            lsum_x;
    logic [LO_BITS:0]            lsum_y;
    logic signed [VAL_BITS-1:0]  val_x;
    logic signed [VAL_BITS-1:0]  val_y;
    logic signed [VAL_BITS-1:0]  lim_s;
    logic signed [VAL_BITS-1:0]  neg_lim;

    function automatic logic [VEL_BITS-1:0] clamp(
        input logic signed [VAL_BITS-1:0] v,
        input logic signed [VAL_BITS-1:0] hi,
        input logic signed [VAL_BITS-1:0] lo
    );
        logic [VEL_BITS-1:0] r;
        if (v > hi)
        begin
            r = hi[VEL_BITS-1:0];
        end
        else if (v < lo)
        begin
            r = lo[VEL_BITS-1:0];
        end
        else
        begin
            r = v[VEL_BITS-1:0];
        end
        return r;
    endfunction

    // LSB-first shift-add; the top bit of cos/sin carries negative weight
    assign last   = cnt_reg == MUL_CNT_BITS'(CORD_BITS - 1);
    assign p_cx   = cb_reg[0] ? TERM_BITS'(ax_reg) : '0;
    assign p_sy   = sb_reg[0] ? TERM_BITS'(ay_reg) : '0;
    assign p_sx   = sb_reg[0] ? TERM_BITS'(ax_reg) : '0;
    assign p_cy   = cb_reg[0] ? TERM_BITS'(ay_reg) : '0;
    assign tx_raw = p_cx - p_sy;
    assign ty_raw = p_sx + p_cy;
    assign tx     = last ? -tx_raw : tx_raw;
    assign ty     = last ? -ty_raw : ty_raw;
    assign sum_x  = hx_reg + HI_BITS'(tx);
    assign sum_y  = hy_reg + HI_BITS'(ty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ax_reg <= sx;
            ay_reg <= sy;
            cb_reg <= cos_q;
            sb_reg <= sin_q;
            hx_reg <= '0;
            hy_reg <= '0;
        end
        else if (busy_reg)
        begin
            cb_reg <= {1'b0, cb_reg[CORD_BITS-1:1]};
            sb_reg <= {1'b0, sb_reg[CORD_BITS-1:1]};
            hx_reg <= sum_x >>> 1;
            hy_reg <= sum_y >>> 1;
            lx_reg <= {sum_x[0], lx_reg[LO_BITS-1:1]};
            ly_reg <= {sum_y[0], ly_reg[LO_BITS-1:1]};
        end
    end

    // round half up at bit 30: high part scaled up plus carry out of the low word
    assign lsum_x  = {1'b0, lx_reg} + ROUND_HALF;
    assign lsum_y  = {1'b0, ly_reg} + ROUND_HALF;
    assign val_x   = $signed({hx_reg, {(LO_BITS - ROUND_SHIFT){1'b0}}}
                             + VAL_BITS'(lsum_x[LO_BITS:ROUND_SHIFT]));
    assign val_y   = $signed({hy_reg, {(LO_BITS - ROUND_SHIFT){1'b0}}}
                             + VAL_BITS'(lsum_y[LO_BITS:ROUND_SHIFT]));
    assign lim_s   = $signed(VAL_BITS'(limit));
    assign neg_lim = -lim_s;

    assign vel_x = $signed(clamp(val_x, lim_s, neg_lim));
    assign vel_y = $signed(clamp(val_y, lim_s, neg_lim));
    assign busy  = busy_reg;

endmodule

// ===== rtl/optical_flow_velocity_rotate_unit.sv =====
// Channel    Dir   Handshake      Payload
// sample     in    valid/ready    motion_status, flow_x, flow_y, surface_quality,
//                                 shutter_upper, heading, stamp_us
// velocity   out   valid/ready    vel_x, vel_y, moved
// apb        in    psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// One item at a time: a taken item passes LOAD, SOLVE, TURN, ROTATE and EMIT
// before the next is taken. The 31-step bit-serial divider (CORDIC runs alongside)
// runs in SOLVE, the 32-step serial rotation multiply in ROTATE.
// The result sits in an output register, so the next item is taken while it waits.
// rst_n is asynchronous, active low; control and APB registers reset, data registers not.
module optical_flow_velocity_rotate_unit import ofvr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    ofvr_in_if.sink               sample,
    ofvr_out_if.source            velocity,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    ofvr_cfg_t                   cfg;
    ofvr_state_t                 state_reg;
    ofvr_state_t                 state_next;
    logic [STAMP_BITS-1:0]       last_stamp_reg;
    logic                        have_last_reg;
    logic                        counted_reg;
    logic [STAMP_BITS-1:0]       dt_reg;
    logic signed [COUNT_BITS-1:0] count_x_reg;
    logic signed [COUNT_BITS-1:0] count_y_reg;
    logic [ANGLE_BITS-1:0]       ang_reg;
    logic                        out_valid_reg;
    logic signed [VEL_BITS-1:0]  vel_x_reg;
    logic signed [VEL_BITS-1:0]  vel_y_reg;
    logic                        moved_reg;

    logic                        in_ready;
    logic                        solve_start;
    logic                        rot_start;
    logic                        out_load;
    logic                        accept;
    logic [STAMP_BITS-1:0]       stamp;
    logic                        fake;
    logic                        counted;
    logic [HEADING_BITS:0]       ang_sum;

    logic                        div_x_busy;
    logic                        div_y_busy;
    logic                        cord_busy;
    logic                        rot_busy;
    logic signed [SC_BITS-1:0]   scaled_x;
    logic signed [SC_BITS-1:0]   scaled_y;
    logic signed [CORD_BITS-1:0] cos_q;
    logic signed [CORD_BITS-1:0] sin_q;
    logic signed [VEL_BITS-1:0]  rot_vel_x;
    logic signed [VEL_BITS-1:0]  rot_vel_y;

    ofvr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign accept = sample.valid && in_ready;
    assign stamp  = STAMP_BITS'(sample.stamp_us);
    assign fake   = (sample.surface_quality < QUALITY_MIN)
                    && (sample.shutter_upper == SHUTTER_FAKE);
    assign counted = sample.motion_status[MOTION_BIT] && !fake && have_last_reg
                     && (stamp != last_stamp_reg);
    assign ang_sum = (HEADING_BITS + 1)'(sample.heading) + (HEADING_BITS + 1)'(cfg.offset);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SOLVE;
            end
            ST_SOLVE:
            begin
                if (!div_x_busy && !div_y_busy && !cord_busy)
                begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN:
            begin
                state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (!rot_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || velocity.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        solve_start = 1'b0;
        rot_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready    = 1'b1;
            ST_LOAD:   solve_start = 1'b1;
            ST_TURN:   rot_start   = 1'b1;
            ST_EMIT:   out_load    = !out_valid_reg || velocity.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_stamp_reg <= '0;
            have_last_reg  <= 1'b0;
            counted_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                last_stamp_reg <= stamp;
                have_last_reg  <= 1'b1;
                counted_reg    <= counted;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (velocity.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg      <= stamp - last_stamp_reg;
            count_x_reg <= sample.flow_x;
            count_y_reg <= sample.flow_y;
            ang_reg     <= ANGLE_BITS'(ang_sum);
        end
        if (out_load)
        begin
            vel_x_reg <= counted_reg ? rot_vel_x : '0;
            vel_y_reg <= counted_reg ? rot_vel_y : '0;
            moved_reg <= counted_reg;
        end
    end

    ofvr_div u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (solve_start),
        .count  (count_x_reg),
        .scale  (cfg.scale),
        .dt     (dt_reg),
        .busy   (div_x_busy),
        .scaled (scaled_x)
    );

    ofvr_div u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (solve_start),
        .count  (count_y_reg),
        .scale  (cfg.scale),
        .dt     (dt_reg),
        .busy   (div_y_busy),
        .scaled (scaled_y)
    );

    ofvr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (solve_start),
        .angle (ang_reg),
        .busy  (cord_busy),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    ofvr_rot u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .sx    (scaled_x),
        .sy    (scaled_y),
        .cos_q (cos_q),
        .sin_q (sin_q),
        .limit (cfg.limit),
        .busy  (rot_busy),
        .vel_x (rot_vel_x),
        .vel_y (rot_vel_y)
    );

    assign sample.ready   = in_ready;
    assign velocity.valid = out_valid_reg;
    assign velocity.vel_x = vel_x_reg;
    assign velocity.vel_y = vel_y_reg;
    assign velocity.moved = moved_reg;

endmodule

// ===== rtl/ofvr_checker.sv =====
module ofvr_checker import ofvr_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [VEL_BITS-1:0] vel_x,
    input logic signed [VEL_BITS-1:0] vel_y,
    input logic                       moved
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vel_x) && $stable(vel_y) && $stable(moved))
        else $error("result changed while stalled");

    a_still_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moved |-> vel_x == '0 && vel_y == '0)
        else $error("nonzero velocity on a sample that did not count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

endmodule

bind optical_flow_velocity_rotate_unit ofvr_checker u_ofvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (velocity.valid),
    .out_ready (velocity.ready),
    .vel_x     (velocity.vel_x),
    .vel_y     (velocity.vel_y),
    .moved     (velocity.moved)
);

// ===== tb/tb.sv =====
module tb;
    import ofvr_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam longint HALF_LSB = 64'sd536870912;
    localparam longint SCALED_CAP = 64'sd2147483647;
    localparam longint UNIT_GAIN = 64'sd652032874;
    localparam int TURN_STEPS = 30;
    localparam logic [31:0] TURN_ATAN [TURN_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    typedef struct packed {
        logic        [STATUS_BITS-1:0]   status;
        logic signed [COUNT_BITS-1:0]    flow_x;
        logic signed [COUNT_BITS-1:0]    flow_y;
        logic        [BYTE_BITS-1:0]     quality;
        logic        [BYTE_BITS-1:0]     shutter;
        logic        [HEADING_BITS-1:0]  heading;
        logic        [STAMP_IN_BITS-1:0] stamp;
    } flow_sample_t;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] vel_x;
        logic signed [VEL_BITS-1:0] vel_y;
        logic                       moved;
    } velocity_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic pready;

    ofvr_in_if  sample_if ();
    ofvr_out_if velocity_if ();

    optical_flow_velocity_rotate_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_if),
        .velocity (velocity_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    flow_sample_t sample_q [$];
    velocity_t    velocity_q [$];

    // predictor state and register copies
    logic [SCALE_BITS-1:0]    cfg_scale = '0;
    logic [OFFSET_BITS-1:0]   cfg_offset = '0;
    logic [LIMIT_BITS-1:0]    cfg_limit = LIMIT_RESET;
    logic [STAMP_BITS-1:0]    last_stamp = '0;
    logic                     have_last = 1'b0;
    logic [STAMP_IN_BITS-1:0] gen_stamp = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int moved_count = 0;

    function automatic longint scaled_count(input logic signed [COUNT_BITS-1:0] cnt,
                                            input logic [STAMP_BITS-1:0] dt);
        longint c;
        logic [63:0] mag;
        logic [63:0] q;
        longint r;
        c = cnt;
        mag = ((c < 0) ? 64'(-c) : 64'(c)) * 64'(cfg_scale);
        q = mag / 64'(dt);
        r = (q > 64'(SCALED_CAP)) ? SCALED_CAP : longint'(q);
        return (c < 0) ? -r : r;
    endfunction

    function automatic longint clamp_speed(input longint v);
        longint lim;
        lim = longint'(cfg_limit);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic velocity_t predict_velocity(input flow_sample_t smp);
        velocity_t res;
        logic [STAMP_BITS-1:0] dt;
        logic fake;
        logic counted;
        logic [ANGLE_BITS-1:0] turn;
        logic [31:0] a32;
        logic [31:0] shifted;
        logic flip;
        longint sx, sy, x, y, z, dx, dy, c, s, vx, vy;
        dt = smp.stamp - last_stamp;
        fake = (smp.quality < QUALITY_MIN) && (smp.shutter == SHUTTER_FAKE);
        counted = smp.status[MOTION_BIT] && !fake && have_last && (dt != 0);
        vx = 0;
        vy = 0;
        if (counted)
        begin
            sx = scaled_count(smp.flow_x, dt);
            sy = scaled_count(smp.flow_y, dt);
            turn = smp.heading + cfg_offset;
            a32 = 32'(turn) << (32 - ANGLE_BITS);
            // fold into [-1/4, 1/4) turn, negate afterwards
            shifted = a32 + 32'h4000_0000;
            flip = shifted[31];
            if (flip)
                a32 = a32 - 32'h8000_0000;
            z = longint'($signed(a32));
            x = UNIT_GAIN;
            y = 0;
            for (int i = 0; i < TURN_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(TURN_ATAN[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(TURN_ATAN[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
            vx = clamp_speed((sx * c - sy * s + HALF_LSB) >>> 30);
            vy = clamp_speed((sx * s + sy * c + HALF_LSB) >>> 30);
        end
        last_stamp = smp.stamp;
        have_last = 1'b1;
        res.vel_x = vx[VEL_BITS-1:0];
        res.vel_y = vy[VEL_BITS-1:0];
        res.moved = counted;
        return res;
    endfunction

    function automatic logic signed [COUNT_BITS-1:0] random_count();
        case ($urandom_range(7))
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: return COUNT_BITS'(int'($urandom_range(400)) - 200);
            default: return COUNT_BITS'($urandom);
        endcase
    endfunction

    task automatic add_sample(input logic [STATUS_BITS-1:0] status,
                              input logic signed [COUNT_BITS-1:0] fx,
                              input logic signed [COUNT_BITS-1:0] fy,
                              input logic [BYTE_BITS-1:0] quality,
                              input logic [BYTE_BITS-1:0] shutter,
                              input logic [HEADING_BITS-1:0] heading,
                              input logic [STAMP_IN_BITS-1:0] stamp);
        sample_q.push_back('{status, fx, fy, quality, shutter, heading, stamp});
        gen_stamp = stamp;
    endtask

    task automatic push_random(input int n);
        flow_sample_t smp;
        logic [STAMP_IN_BITS-1:0] delta;
        for (int k = 0; k < n; k++)
        begin
            smp.status = STATUS_BITS'($urandom);
            smp.status[MOTION_BIT] = ($urandom_range(9) != 0);
            smp.flow_x = random_count();
            smp.flow_y = random_count();
            smp.quality = ($urandom_range(3) == 0) ? BYTE_BITS'($urandom_range(8'h18))
                                                  : BYTE_BITS'($urandom);
            smp.shutter = ($urandom_range(3) == 0) ? SHUTTER_FAKE : BYTE_BITS'($urandom);
            smp.heading = HEADING_BITS'($urandom);
            case ($urandom_range(19))
                0:          delta = '0;
                1, 2, 3:    delta = STAMP_IN_BITS'($urandom_range(255) + 1);
                4, 5, 6, 7: delta = STAMP_IN_BITS'($urandom_range(65535, 256));
                19:         delta = STAMP_IN_BITS'({$urandom, $urandom});
                default:    delta = STAMP_IN_BITS'($urandom_range(24'hFF_FFFF, 65536));
            endcase
            gen_stamp = gen_stamp + delta;
            smp.stamp = gen_stamp;
            sample_q.push_back(smp);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCALE:  cfg_scale = value;
            REG_OFFSET: cfg_offset = value[OFFSET_BITS-1:0];
            REG_LIMIT:  cfg_limit = value[LIMIT_BITS-1:0];
            default:    ;
        endcase
    endtask

    // hold off until every queued item is taken and its velocity has come back;
    // checked mid-cycle so the clocked driver and monitors have settled
    task automatic drain();
        while (sample_q.size() != 0 || sample_if.valid || velocity_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        flow_sample_t nxt;
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
        end
        else if (!sample_if.valid || sample_if.ready)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = sample_q.pop_front();
                sample_if.valid <= 1'b1;
                sample_if.motion_status <= nxt.status;
                sample_if.flow_x <= nxt.flow_x;
                sample_if.flow_y <= nxt.flow_y;
                sample_if.surface_quality <= nxt.quality;
                sample_if.shutter_upper <= nxt.shutter;
                sample_if.heading <= nxt.heading;
                sample_if.stamp_us <= nxt.stamp;
            end
            else
            begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        velocity_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        flow_sample_t taken;
        velocity_t want;
        if (rst_n && sample_if.valid && sample_if.ready)
        begin
            taken.status = sample_if.motion_status;
            taken.flow_x = sample_if.flow_x;
            taken.flow_y = sample_if.flow_y;
            taken.quality = sample_if.surface_quality;
            taken.shutter = sample_if.shutter_upper;
            taken.heading = sample_if.heading;
            taken.stamp = sample_if.stamp_us;
            want = predict_velocity(taken);
            if (want.moved)
                moved_count++;
            velocity_q.push_back(want);
        end
    end

    always @(posedge clk)
    begin
        velocity_t want;
        if (rst_n && velocity_if.valid && velocity_if.ready)
        begin
            if (velocity_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected velocity item: vel_x=%0d vel_y=%0d moved=%0b",
                             velocity_if.vel_x, velocity_if.vel_y, velocity_if.moved);
                mismatch_count++;
            end
            else
            begin
                want = velocity_q.pop_front();
                checked_count++;
                if (velocity_if.vel_x !== want.vel_x || velocity_if.vel_y !== want.vel_y ||
                    velocity_if.moved !== want.moved)
                begin
                    if (mismatch_count < 10)
                        $display({"item %0d: expected vel_x=%0d vel_y=%0d moved=%0b,",
                                  " got %0d %0d %0b"},
                                 checked_count, want.vel_x, want.vel_y, want.moved,
                                 velocity_if.vel_x, velocity_if.vel_y, velocity_if.moved);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("optical_flow_velocity_rotate_unit verification failed");
        $finish;
    end

    initial
    begin
        sample_if.valid = 1'b0;
        sample_if.motion_status = '0;
        sample_if.flow_x = '0;
        sample_if.flow_y = '0;
        sample_if.surface_quality = '0;
        sample_if.shutter_upper = '0;
        sample_if.heading = '0;
        sample_if.stamp_us = '0;
        velocity_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 86;
        write_reg(REG_SCALE, 32'd1_000_000);
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_LIMIT, 32'd131071);
        // no earlier sample
        add_sample(8'hFF, 16'sd100, 16'sd50, 8'h80, 8'h00, 16'h0000, 48'd1000);
        add_sample(8'h80, 16'sd100, 16'sd50, 8'h80, 8'h00, 16'h0000, 48'd2000);
        add_sample(8'h80, 16'sd100, 16'sd50, 8'h80, 8'h00, 16'h4000, 48'd3000);
        add_sample(8'h80, -16'sd100, 16'sd50, 8'h80, 8'h00, 16'h8000, 48'd4000);
        add_sample(8'h80, 16'sd100, -16'sd50, 8'h80, 8'h00, 16'hC000, 48'd5000);
        add_sample(8'hFF, 16'sh7FFF, 16'sh8000, 8'hFF, 8'hFF, 16'hFFFF, 48'd1_005_000);
        // no motion
        add_sample(8'h7F, 16'sd100, 16'sd100, 8'h80, 8'h00, 16'h1000, 48'd1_006_000);
        // fake report
        add_sample(8'h80, 16'sd100, 16'sd100, 8'h18, 8'h1F, 16'h1000, 48'd1_007_000);
        add_sample(8'h80, 16'sd100, 16'sd100, 8'h19, 8'h1F, 16'h1000, 48'd1_008_000);
        add_sample(8'h80, 16'sd100, 16'sd100, 8'h00, 8'h1E, 16'h1000, 48'd1_009_000);
        // zero elapsed
        add_sample(8'h80, 16'sd100, 16'sd100, 8'h80, 8'h00, 16'h1000, 48'd1_009_000);
        add_sample(8'h80, 16'sh8000, 16'sh7FFF, 8'h80, 8'h00, 16'h2000, 48'd1_009_001);
        add_sample(8'h80, 16'sd1, 16'sd1, 8'h80, 8'h00, 16'h3000, 48'hFFFF_FFFF_FFFF);
        // stamp wraps
        add_sample(8'h80, 16'sd1000, -16'sd1000, 8'h80, 8'h00, 16'h5000, 48'd5);
        add_sample(8'h80, 16'sd0, 16'sd0, 8'h00, 8'h00, 16'h0000, 48'd0);
        add_sample(8'h80, -16'sd1, -16'sd1, 8'h80, 8'h00, 16'h7000, 48'd1000);
        drain();
        write_reg(REG_OFFSET, 32'h0000_FFFF);
        write_reg(REG_SPARE, 32'hA5A5_5A5A);
        add_sample(8'h80, 16'sd300, 16'sd200, 8'h80, 8'h00, 16'h0001, 48'd2000);
        add_sample(8'h80, 16'sd300, 16'sd200, 8'h80, 8'h00, 16'h8000, 48'd3000);
        add_sample(8'hFF, -16'sd300, 16'sd200, 8'h80, 8'h00, 16'hFFFF, 48'd4000);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 86 : 0;
            recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 21 : 0;
            case (phase)
                0:
                begin
                    write_reg(REG_SCALE, 32'hFFFF_FFFF);
                    write_reg(REG_OFFSET, 32'h0000_FFFF);
                    write_reg(REG_LIMIT, 32'd131071);
                end
                1:
                begin
                    write_reg(REG_SCALE, $urandom_range(5_000_000, 1));
                    write_reg(REG_OFFSET, $urandom_range(16'hFFFF));
                    write_reg(REG_LIMIT, 32'(LIMIT_RESET));
                end
                2:
                begin
                    write_reg(REG_SCALE, 32'd0);
                    write_reg(REG_OFFSET, 32'd0);
                    write_reg(REG_LIMIT, 32'd0);
                end
                3:
                begin
                    write_reg(REG_SCALE, $urandom);
                    write_reg(REG_OFFSET, $urandom_range(16'hFFFF));
                    write_reg(REG_LIMIT, $urandom_range(17'h1FFFF));
                end
                4:
                begin
                    write_reg(REG_SCALE, $urandom_range(5_000_000, 1));
                    write_reg(REG_OFFSET, $urandom_range(16'hFFFF));
                    write_reg(REG_LIMIT, 32'd131071);
                end
                default:
                begin
                    write_reg(REG_SCALE, $urandom_range(100_000, 1));
                    write_reg(REG_OFFSET, 32'h0000_8000);
                    write_reg(REG_LIMIT, $urandom_range(1000));
                end
            endcase
            // sender pauses mid-phase until the block has emptied out
            push_random(75);
            drain();
            push_random(75);
            drain();
        end

        repeat (80) @(posedge clk);
        $display("checked %0d velocity items, %0d of them counted as motion,", checked_count,
                 moved_count);
        $display("over directed corner cases and six register settings under three stall mixes");
        if (mismatch_count == 0 && velocity_q.size() == 0)
            $display("optical_flow_velocity_rotate_unit verification clean");
        else
            $display("optical_flow_velocity_rotate_unit verification failed");
        $finish;
    end

endmodule
